>>> hdl/tmpq_pkg.sv
// Shared types and constants for the tagged max priority queue.
// No dependencies; used by the cell, the top level and the checker.
`default_nettype none

package tmpq_pkg;

   // Field widths of one item
   localparam int KIND_W    = 2;
   localparam int GAIN_W    = 32;
   localparam int TAG_W     = 6;
   localparam int PAYLOAD_W = 32;
   localparam int KEY_W     = GAIN_W + 1;
   localparam int COUNT_W   = 9;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // One stored entry
   typedef struct packed {
      logic signed [GAIN_W-1:0] gain;
      logic signed [GAIN_W-1:0] gainrev;
      logic [TAG_W-1:0]         child;
      logic [PAYLOAD_W-1:0]     payload;
   } entry_type;

   // Operation broadcast to every cell
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_MARK,
      OP_COMPACT,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      entry_type               entry;   // new entry, or the tag to drop in child
      logic signed [KEY_W-1:0] key;     // key of the new entry
      logic                    phase;   // odd/even pairing of compaction rounds
   } cell_cmd_type;

   // What a cell shows its neighbors
   typedef struct packed {
      entry_type               entry;
      logic signed [KEY_W-1:0] key;
      logic                    valid;
      logic                    ins;     // new entry ranks ahead of this cell
   } cell_link_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COMPACT,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

>>> hdl/tmpq_cell.sv
// One cell of the sorted entry chain: holds an entry, its key and a valid bit.
// Depends on tmpq_pkg; talks only to its left and right neighbors.
`default_nettype none

module tmpq_cell #(
   parameter bit PARITY = 1'b0
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire tmpq_pkg::cell_cmd_type  cmd,
   input  wire tmpq_pkg::cell_link_type left,
   input  wire tmpq_pkg::cell_link_type right,
   output tmpq_pkg::cell_link_type      own
);

   tmpq_pkg::entry_type               entry_ff, entry_in;
   logic signed [tmpq_pkg::KEY_W-1:0] key_ff, key_in;
   logic                              valid_ff, valid_in;
   logic                              ins;

   // Strictly greater key goes ahead; equal keys stay behind older ones
   assign ins = !valid_ff || (cmd.key > key_ff);

   always_comb begin
      entry_in = entry_ff;
      key_in   = key_ff;
      valid_in = valid_ff;
      unique case (cmd.op)
         tmpq_pkg::OP_HOLD: begin
         end
         tmpq_pkg::OP_INSERT: begin
            // Shift right behind the insertion point, take the new entry at it
            if (left.ins) begin
               entry_in = left.entry;
               key_in   = left.key;
               valid_in = left.valid;
            end else if (ins) begin
               entry_in = cmd.entry;
               key_in   = cmd.key;
               valid_in = 1'b1;
            end
         end
         tmpq_pkg::OP_MARK: begin
            if (valid_ff && (entry_ff.child == cmd.entry.child)) begin
               valid_in = 1'b0;
            end
         end
         tmpq_pkg::OP_COMPACT: begin
            // Odd-even rounds: a hole trades places with a valid right neighbor
            if (cmd.phase == PARITY) begin
               if (!valid_ff && right.valid) begin
                  entry_in = right.entry;
                  key_in   = right.key;
                  valid_in = 1'b1;
               end
            end else begin
               if (!left.valid && valid_ff) begin
                  valid_in = 1'b0;
               end
            end
         end
         tmpq_pkg::OP_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
      key_ff   <= key_in;
   end

   assign own.entry = entry_ff;
   assign own.key   = key_ff;
   assign own.valid = valid_ff;
   assign own.ins   = ins;

endmodule

`default_nettype wire

>>> hdl/tagged_max_priority_queue.sv
// Tagged max priority queue: a chain of CAPACITY cells kept sorted by key,
// with a small sequencer in front. Depends on tmpq_pkg and tmpq_cell.
//
// Entries are held in a row of cells sorted by key gain+gainrev (33-bit signed),
// largest first, equal keys in insertion order, so the head is always cell 0.
// One item is worked at a time. An add, a clear, a no-op kind or an item whose
// tag is not below NUM_TAGS goes through IDLE, which takes the item, EXEC, in
// which the cells act, and FINISH, which loads the result. A remove goes through
// IDLE, EXEC, where the matching cells are marked empty, and COMPACT, where the
// holes move to the tail by odd-even neighbor swaps, one round a cycle, until
// COMPACT finds no hole in front of an entry and latches the new count; that is
// at most CAPACITY rounds and usually far fewer. FINISH then loads the result.
// The load of a result waits while the previous result is still unaccepted. A new
// item is taken while an earlier result still waits on rsp_ready. No clearing pass
// is needed after reset.
`default_nettype none

module tagged_max_priority_queue #(
   parameter int CAPACITY = 256,
   parameter int NUM_TAGS = 64
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // Request channel
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [tmpq_pkg::KIND_W-1:0]           req_kind,
   input  wire  signed [tmpq_pkg::GAIN_W-1:0]    req_gain_in,
   input  wire  signed [tmpq_pkg::GAIN_W-1:0]    req_gainrev_in,
   input  wire  [tmpq_pkg::TAG_W-1:0]            req_child_in,
   input  wire  [tmpq_pkg::PAYLOAD_W-1:0]        req_payload_in,
   // Response channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic                                  rsp_head_valid,
   output logic signed [tmpq_pkg::GAIN_W-1:0]    rsp_head_gain,
   output logic signed [tmpq_pkg::GAIN_W-1:0]    rsp_head_gainrev,
   output logic [tmpq_pkg::TAG_W-1:0]            rsp_head_child,
   output logic [tmpq_pkg::PAYLOAD_W-1:0]        rsp_head_payload,
   output logic [tmpq_pkg::COUNT_W-1:0]          rsp_entry_count,
   output logic                                  rsp_overflow
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Sequencer and item registers
   tmpq_pkg::state_type               state_ff, state_in;
   logic [tmpq_pkg::KIND_W-1:0]       kind_ff;
   tmpq_pkg::entry_type               item_ff;
   logic signed [tmpq_pkg::KEY_W-1:0] item_key_ff;
   logic                              tag_ok_ff;
   logic                              phase_ff, phase_in;
   logic                              ovf_ff, ovf_in;
   logic [CNT_W-1:0]                  count_ff, count_in;

   // Response register
   logic                              rsp_valid_ff, rsp_valid_in;
   tmpq_pkg::entry_type               rsp_entry_ff;
   logic                              rsp_head_valid_ff;
   logic [tmpq_pkg::COUNT_W-1:0]      rsp_count_ff;
   logic                              rsp_ovf_ff;

   tmpq_pkg::cell_op_type             op;
   tmpq_pkg::cell_cmd_type            cmd;
   tmpq_pkg::cell_link_type           links [CAPACITY];
   tmpq_pkg::cell_link_type           left_edge, right_edge;
   logic                              accept, load_rsp, full, pending;
   logic [CNT_W-1:0]                  enc_count;
   logic [CNT_W+tmpq_pkg::COUNT_W-1:0] count_ext;

   assign accept = req_valid && req_ready;

   // Broadcast command
   assign cmd.op    = op;
   assign cmd.entry = item_ff;
   assign cmd.key   = item_key_ff;
   assign cmd.phase = phase_ff;

   // Chain ends: nothing ranks ahead of cell 0, nothing stands after the last
   assign left_edge.entry  = '0;
   assign left_edge.key    = '0;
   assign left_edge.valid  = 1'b1;
   assign left_edge.ins    = 1'b0;
   assign right_edge.entry = '0;
   assign right_edge.key   = '0;
   assign right_edge.valid = 1'b0;
   assign right_edge.ins   = 1'b0;

   // Cell chain
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
         tmpq_cell #(.PARITY(1'(g % 2))) u_cell (
            .clock (clock),
            .reset (reset),
            .cmd   (cmd),
            .left  (left_edge),
            .right (links[g+1]),
            .own   (links[g])
         );
      end else if (g == CAPACITY - 1) begin : g_last
         tmpq_cell #(.PARITY(1'(g % 2))) u_cell (
            .clock (clock),
            .reset (reset),
            .cmd   (cmd),
            .left  (links[g-1]),
            .right (right_edge),
            .own   (links[g])
         );
      end else begin : g_mid
         tmpq_cell #(.PARITY(1'(g % 2))) u_cell (
            .clock (clock),
            .reset (reset),
            .cmd   (cmd),
            .left  (links[g-1]),
            .right (links[g+1]),
            .own   (links[g])
         );
      end
   end

   assign full = links[CAPACITY-1].valid;

   // A hole in front of an entry means compaction is not finished
   always_comb begin
      pending = 1'b0;
      for (int i = 0; i < CAPACITY - 1; i++) begin
         pending = pending | (!links[i].valid && links[i+1].valid);
      end
   end

   // Valid bits form a prefix once compacted; encode where it ends
   always_comb begin
      enc_count = '0;
      for (int i = 1; i < CAPACITY; i++) begin
         if (links[i-1].valid && !links[i].valid) begin
            enc_count = enc_count | CNT_W'(i);
         end
      end
      if (links[CAPACITY-1].valid) begin
         enc_count = enc_count | CNT_W'(CAPACITY);
      end
   end

   // Next state and cell command
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      op        = tmpq_pkg::OP_HOLD;
      count_in  = count_ff;
      phase_in  = phase_ff;
      ovf_in    = ovf_ff;
      load_rsp  = 1'b0;
      unique case (state_ff)
         tmpq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ovf_in   = 1'b0;
               state_in = tmpq_pkg::ST_EXEC;
            end
         end
         tmpq_pkg::ST_EXEC: begin
            state_in = tmpq_pkg::ST_FINISH;
            priority if (tag_ok_ff && (kind_ff == tmpq_pkg::KIND_ADD)) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  op       = tmpq_pkg::OP_INSERT;
                  count_in = CNT_W'(count_ff + 1'b1);
               end
            end else if (tag_ok_ff && (kind_ff == tmpq_pkg::KIND_REMOVE)) begin
               op       = tmpq_pkg::OP_MARK;
               phase_in = 1'b0;
               state_in = tmpq_pkg::ST_COMPACT;
            end else if (kind_ff == tmpq_pkg::KIND_CLEAR) begin
               op       = tmpq_pkg::OP_CLEAR;
               count_in = '0;
            end else begin
            end
         end
         tmpq_pkg::ST_COMPACT: begin
            if (pending) begin
               op       = tmpq_pkg::OP_COMPACT;
               phase_in = !phase_ff;
            end else begin
               count_in = enc_count;
               state_in = tmpq_pkg::ST_FINISH;
            end
         end
         tmpq_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = tmpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tmpq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign count_ext    = (CNT_W + tmpq_pkg::COUNT_W)'(count_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmpq_pkg::ST_IDLE;
         count_ff     <= '0;
         phase_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured item
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff         <= req_kind;
         item_ff.gain    <= req_gain_in;
         item_ff.gainrev <= req_gainrev_in;
         item_ff.child   <= req_child_in;
         item_ff.payload <= req_payload_in;
         item_key_ff     <= tmpq_pkg::KEY_W'(req_gain_in)
                            + tmpq_pkg::KEY_W'(req_gainrev_in);
         tag_ok_ff       <= (int'(req_child_in) < NUM_TAGS);
      end
   end

   // Result register: head is cell 0, zeroed when empty
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_entry_ff      <= links[0].valid ? links[0].entry : '0;
         rsp_head_valid_ff <= links[0].valid;
         rsp_count_ff      <= count_ext[tmpq_pkg::COUNT_W-1:0];
         rsp_ovf_ff        <= ovf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_head_valid   = rsp_head_valid_ff;
   assign rsp_head_gain    = rsp_entry_ff.gain;
   assign rsp_head_gainrev = rsp_entry_ff.gainrev;
   assign rsp_head_child   = rsp_entry_ff.child;
   assign rsp_head_payload = rsp_entry_ff.payload;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

`default_nettype wire

>>> hdl/tmpq_checker.sv
// Port-level checks for the tagged max priority queue, bound to the top level.
// Depends on tmpq_pkg for field widths.
`default_nettype none

module tmpq_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_ready,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire                                rsp_head_valid,
   input wire signed [tmpq_pkg::GAIN_W-1:0]  rsp_head_gain,
   input wire [tmpq_pkg::PAYLOAD_W-1:0]      rsp_head_payload,
   input wire [tmpq_pkg::COUNT_W-1:0]        rsp_entry_count,
   input wire                                rsp_overflow
);

   // Items taken but not yet answered
   logic [1:0] outstanding_ff, outstanding_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take && (outstanding_ff != 2'd3)) begin
         outstanding_in = outstanding_ff + 2'd1;
      end else if (!req_take && rsp_take && (outstanding_ff != 2'd0)) begin
         outstanding_in = outstanding_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 2'd0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_head_gain)
         && $stable(rsp_head_payload) && $stable(rsp_entry_count))
      else $error("stalled result changed");

   // Every result answers an item that was taken
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (outstanding_ff != 2'd0))
      else $error("result without a pending item");

   // A new item is taken only while at most one earlier item is still unanswered
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (outstanding_ff == 2'd0) || (outstanding_ff == 2'd1))
      else $error("item taken while another is still in work");

   // An empty head with the overflow flag set must come with an entry count of zero
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_head_valid || rsp_overflow)
         |-> (rsp_head_valid == rsp_overflow) || (rsp_entry_count == '0)
            || rsp_head_valid)
      else $error("head flag disagrees with entry count");

endmodule

bind tagged_max_priority_queue tmpq_checker u_tmpq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_head_valid   (rsp_head_valid),
   .rsp_head_gain    (rsp_head_gain),
   .rsp_head_payload (rsp_head_payload),
   .rsp_entry_count  (rsp_entry_count),
   .rsp_overflow     (rsp_overflow)
);

`default_nettype wire
